// ----- rtl/npcd_pkg.sv -----
// Shared types, sizes and codes for the non-preemptive dispatcher.
// Used by every module of the block but npcd_ram; depends on nothing else.

package npcd_pkg;

   localparam int QUEUE_DEPTH     = 16;
   localparam int TIME_WIDTH      = 16;
   localparam int TAG_WIDTH       = 8;
   localparam int BURST_WIDTH     = 16;
   localparam int PRIO_WIDTH      = 8;
   localparam int POLICY_WIDTH    = 2;
   localparam int QIDX_WIDTH      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH      = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_DATA_WIDTH  = TIME_WIDTH;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CMDQ_DEPTH      = 2;
   localparam int CMDQ_PTR_WIDTH  = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_WIDTH  = $clog2(CMDQ_DEPTH + 1);

   localparam logic [POLICY_WIDTH-1:0] POL_FCFS = 2'd0;
   localparam logic [POLICY_WIDTH-1:0] POL_SJF  = 2'd1;
   localparam logic [POLICY_WIDTH-1:0] POL_PRIO = 2'd2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_POLICY     = 1'b0,
      CSR_TIME_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic {
      CMD_ARRIVE = 1'b0,
      CMD_TICK   = 1'b1
   } cmd_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_SHIFT,
      BK_EXEC
   } back_state_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [TAG_WIDTH-1:0]   tag;
      logic [BURST_WIDTH-1:0] burst;
      logic [PRIO_WIDTH-1:0]  prio;
   } cmd_type;

   typedef struct packed {
      logic [TAG_WIDTH-1:0]   tag;
      logic [BURST_WIDTH-1:0] burst;
      logic [PRIO_WIDTH-1:0]  prio;
      logic [TIME_WIDTH-1:0]  arrival;
   } entry_type;

   localparam int ENTRY_WIDTH = $bits(entry_type);

   typedef struct packed {
      logic [POLICY_WIDTH-1:0] policy;
      logic [TIME_WIDTH-1:0]   time_limit;
   } cfg_type;

   typedef struct packed {
      logic                  stopped;
      logic                  busy_res;
      logic [TAG_WIDTH-1:0]  running_tag;
      logic [TIME_WIDTH-1:0] tick_time;
      logic                  finished;
      logic [TIME_WIDTH-1:0] finish_time;
      logic [TIME_WIDTH-1:0] turnaround;
      logic [TIME_WIDTH-1:0] wait_time;
      logic                  arrival_lost;
   } rsp_type;

endpackage

// ----- rtl/nonpreemptive_cpu_dispatcher.sv -----
// A stopped tick strobes its result from the idle state, a tick that starts no job from the
// execute state; one that picks a queued job first passes through scan and shift,
// as the ready RAM is read once per cycle to select and once per cycle to close the gap.
// The back end takes one command at a time; an arrive is done in the idle state, and a tick
// holds it until it is back in idle. busy rises when the two-entry command queue is full.
// Synchronous reset empties both queues, zeroes the time and restores the policy and limit.

module nonpreemptive_cpu_dispatcher
   import npcd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_operation,
   input  logic [TAG_WIDTH-1:0]       req_job_tag,
   input  logic [BURST_WIDTH-1:0]     req_burst,
   input  logic [PRIO_WIDTH-1:0]      req_priority_req,
   output logic                       rsp_valid,
   output logic                       rsp_stopped,
   output logic                       rsp_busy_res,
   output logic [TAG_WIDTH-1:0]       rsp_running_tag,
   output logic [TIME_WIDTH-1:0]      rsp_tick_time,
   output logic                       rsp_finished,
   output logic [TIME_WIDTH-1:0]      rsp_finish_time,
   output logic [TIME_WIDTH-1:0]      rsp_turnaround,
   output logic [TIME_WIDTH-1:0]      rsp_wait_time,
   output logic                       rsp_arrival_lost,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic [POLICY_WIDTH-1:0] policy_ff, policy_in;
   logic [TIME_WIDTH-1:0]   time_limit_ff, time_limit_in;
   cfg_type                 cfg;
   cmd_type                 cmd;
   logic                    cmd_valid;
   logic                    cmd_pop;
   rsp_type                 rsp;

   always_comb begin
      policy_in     = policy_ff;
      time_limit_in = time_limit_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_POLICY:     policy_in     = csr_wdata[POLICY_WIDTH-1:0];
            CSR_TIME_LIMIT: time_limit_in = csr_wdata[TIME_WIDTH-1:0];
            default:        policy_in     = policy_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff     <= POL_FCFS;
         time_limit_ff <= '1;
      end else begin
         policy_ff     <= policy_in;
         time_limit_ff <= time_limit_in;
      end
   end

   assign cfg.policy     = policy_ff;
   assign cfg.time_limit = time_limit_ff;

   npcd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_job_tag      (req_job_tag),
      .req_burst        (req_burst),
      .req_priority_req (req_priority_req),
      .cmd              (cmd),
      .cmd_valid        (cmd_valid),
      .cmd_pop          (cmd_pop)
   );

   npcd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_stopped      = rsp.stopped;
   assign rsp_busy_res     = rsp.busy_res;
   assign rsp_running_tag  = rsp.running_tag;
   assign rsp_tick_time    = rsp.tick_time;
   assign rsp_finished     = rsp.finished;
   assign rsp_finish_time  = rsp.finish_time;
   assign rsp_turnaround   = rsp.turnaround;
   assign rsp_wait_time    = rsp.wait_time;
   assign rsp_arrival_lost = rsp.arrival_lost;

endmodule

// ----- rtl/npcd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.

module npcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/npcd_front.sv -----
// Front end: takes request transfers, decodes the operation and holds them
// in a short command queue for the back end. Depends on npcd_pkg.

module npcd_front
   import npcd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_operation,
   input  logic [TAG_WIDTH-1:0]   req_job_tag,
   input  logic [BURST_WIDTH-1:0] req_burst,
   input  logic [PRIO_WIDTH-1:0]  req_priority_req,
   output cmd_type                cmd,
   output logic                   cmd_valid,
   input  logic                   cmd_pop
);

   cmd_type                   cmdq_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                      push;
   cmd_type                   new_cmd;

   function automatic logic [CMDQ_PTR_WIDTH-1:0] next_ptr(
      input logic [CMDQ_PTR_WIDTH-1:0] ptr
   );
      if (ptr == CMDQ_PTR_WIDTH'(CMDQ_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   assign busy      = (cnt_ff == CMDQ_CNT_WIDTH'(CMDQ_DEPTH));
   assign push      = start && !busy;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = cmdq_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.kind  = req_operation ? CMD_TICK : CMD_ARRIVE;
      new_cmd.tag   = req_job_tag;
      new_cmd.burst = req_burst;
      new_cmd.prio  = req_priority_req;

      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      case ({push, cmd_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmdq_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command queue popped while empty");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CMDQ_CNT_WIDTH'(CMDQ_DEPTH))
      else $error("command queue count overflow");

endmodule

// ----- rtl/npcd_back.sv -----
// Back end: carries out arrive and tick commands against the ready queue
// RAM, selects and compacts, runs the job and forms the result.
// Depends on npcd_pkg and npcd_ram.

module npcd_back
   import npcd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  cmd_type cmd,
   input  logic    cmd_valid,
   output logic    cmd_pop,
   output logic    rsp_valid,
   output rsp_type rsp
);

   back_state_type         st_ff, st_in;
   logic [QCNT_WIDTH-1:0]  count_ff, count_in;
   logic [QCNT_WIDTH-1:0]  issue_ff, issue_in;
   logic                   pend_ff, pend_in;
   logic [QIDX_WIDTH-1:0]  pend_pos_ff, pend_pos_in;
   logic [QIDX_WIDTH-1:0]  best_pos_ff, best_pos_in;
   entry_type              best_ff, best_in;
   logic                   run_valid_ff, run_valid_in;
   logic [TAG_WIDTH-1:0]   run_tag_ff, run_tag_in;
   logic [BURST_WIDTH-1:0] run_rem_ff, run_rem_in;
   logic [TIME_WIDTH-1:0]  run_arr_ff, run_arr_in;
   logic [TIME_WIDTH-1:0]  run_start_ff, run_start_in;
   logic [TIME_WIDTH-1:0]  now_ff, now_in;
   logic                   lost_ff, lost_in;
   logic                   lost_rpt_ff, lost_rpt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   ram_we;
   logic [QIDX_WIDTH-1:0]  ram_waddr;
   logic [ENTRY_WIDTH-1:0] ram_wdata;
   logic [ENTRY_WIDTH-1:0] ram_rdata;
   entry_type              rd_entry;
   entry_type              arr_entry;
   logic                   issue;
   logic [TIME_WIDTH-1:0]  fin;

   npcd_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_ready_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (issue_ff[QIDX_WIDTH-1:0]),
      .rdata (ram_rdata)
   );

   function automatic logic better(
      input entry_type               cand,
      input entry_type               best,
      input logic [POLICY_WIDTH-1:0] policy
   );
      case (policy)
         POL_FCFS: return 1'b0;
         POL_SJF:  return cand.burst < best.burst;
         default:  return cand.prio < best.prio;
      endcase
   endfunction

   assign rd_entry  = entry_type'(ram_rdata);
   assign issue     = (issue_ff < count_ff);
   assign fin       = now_ff + 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      arr_entry.tag     = cmd.tag;
      arr_entry.burst   = cmd.burst;
      arr_entry.prio    = cmd.prio;
      arr_entry.arrival = now_ff;

      st_in        = st_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      pend_pos_in  = pend_pos_ff;
      best_pos_in  = best_pos_ff;
      best_in      = best_ff;
      run_valid_in = run_valid_ff;
      run_tag_in   = run_tag_ff;
      run_rem_in   = run_rem_ff;
      run_arr_in   = run_arr_ff;
      run_start_in = run_start_ff;
      now_in       = now_ff;
      lost_in      = lost_ff;
      lost_rpt_in  = lost_rpt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = count_ff[QIDX_WIDTH-1:0];
      ram_wdata    = arr_entry;

      case (st_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.kind == CMD_ARRIVE) begin
                  if (count_ff < QCNT_WIDTH'(QUEUE_DEPTH)) begin
                     ram_we   = 1'b1;
                     count_in = count_ff + 1'b1;
                  end else begin
                     lost_in = 1'b1;
                  end
               end else begin
                  lost_rpt_in = lost_ff;
                  lost_in     = 1'b0;
                  if (now_ff >= cfg.time_limit) begin
                     rsp_valid_in        = 1'b1;
                     rsp_in              = '0;
                     rsp_in.stopped      = 1'b1;
                     rsp_in.tick_time    = now_ff;
                     rsp_in.arrival_lost = lost_ff;
                  end else if (!run_valid_ff && count_ff != '0) begin
                     st_in       = BK_SCAN;
                     issue_in    = '0;
                     best_pos_in = '0;
                  end else begin
                     st_in = BK_EXEC;
                  end
               end
            end
         end

         BK_SCAN: begin
            // Reads go out one per cycle; the data comes back in the cycle after each.
            if (issue) begin
               issue_in    = issue_ff + 1'b1;
               pend_in     = 1'b1;
               pend_pos_in = issue_ff[QIDX_WIDTH-1:0];
            end
            if (pend_ff) begin
               if (pend_pos_ff == '0 || better(rd_entry, best_ff, cfg.policy)) begin
                  best_in     = rd_entry;
                  best_pos_in = pend_pos_ff;
               end
            end
            if (!issue && !pend_ff) begin
               st_in    = BK_SHIFT;
               issue_in = QCNT_WIDTH'(best_pos_ff) + 1'b1;
            end
         end

         BK_SHIFT: begin
            // Each entry behind the chosen one moves down by one place.
            if (issue) begin
               issue_in    = issue_ff + 1'b1;
               pend_in     = 1'b1;
               pend_pos_in = issue_ff[QIDX_WIDTH-1:0];
            end
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pend_pos_ff - 1'b1;
               ram_wdata = ram_rdata;
            end
            if (!issue && !pend_ff) begin
               count_in     = count_ff - 1'b1;
               run_valid_in = 1'b1;
               run_tag_in   = best_ff.tag;
               run_rem_in   = best_ff.burst;
               run_arr_in   = best_ff.arrival;
               run_start_in = now_ff;
               st_in        = BK_EXEC;
            end
         end

         BK_EXEC: begin
            rsp_valid_in        = 1'b1;
            rsp_in              = '0;
            rsp_in.tick_time    = now_ff;
            rsp_in.arrival_lost = lost_rpt_ff;
            if (run_valid_ff) begin
               rsp_in.busy_res    = 1'b1;
               rsp_in.running_tag = run_tag_ff;
               if (run_rem_ff <= BURST_WIDTH'(1)) begin
                  rsp_in.finished    = 1'b1;
                  rsp_in.finish_time = fin;
                  rsp_in.turnaround  = fin - run_arr_ff;
                  rsp_in.wait_time   = run_start_ff - run_arr_ff;
                  run_valid_in       = 1'b0;
                  run_rem_in         = '0;
               end else begin
                  run_rem_in = run_rem_ff - 1'b1;
               end
            end
            now_in = fin;
            st_in  = BK_IDLE;
         end

         default: begin
            st_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pend_pos_ff <= pend_pos_in;
      best_pos_ff <= best_pos_in;
      best_ff     <= best_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= BK_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         run_valid_ff <= 1'b0;
         run_tag_ff   <= '0;
         run_rem_ff   <= '0;
         run_arr_ff   <= '0;
         run_start_ff <= '0;
         now_ff       <= '0;
         lost_ff      <= 1'b0;
         lost_rpt_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         run_valid_ff <= run_valid_in;
         run_tag_ff   <= run_tag_in;
         run_rem_ff   <= run_rem_in;
         run_arr_ff   <= run_arr_in;
         run_start_ff <= run_start_in;
         now_ff       <= now_in;
         lost_ff      <= lost_in;
         lost_rpt_ff  <= lost_rpt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_WIDTH'(QUEUE_DEPTH))
      else $error("ready queue count beyond depth");

   a_no_dispatch_while_running: assert property (@(posedge clock) disable iff (reset)
      (st_ff == BK_SCAN || st_ff == BK_SHIFT) |-> !run_valid_ff && count_ff != '0)
      else $error("selection started while a job runs or queue empty");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(st_ff) == BK_EXEC ||
                        ($past(st_ff) == BK_IDLE && $past(cmd_pop))))
      else $error("result strobe without a tick being finished");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the non-preemptive dispatcher: directed steps, then random
// arrive and tick transfers checked against a predictor of the dispatch policies.
// Depends on rtl/npcd_pkg.sv and rtl/nonpreemptive_cpu_dispatcher.sv only.

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import npcd_pkg::*;

   localparam int PERIOD        = 8;
   localparam int SETTLE_CYCLES = 64;
   localparam int NUM_PHASES    = 6;
   localparam int RANDOM_ITEMS  = 1550;
   // The policy code with no meaning of its own; the block treats it as priority.
   localparam logic [POLICY_WIDTH-1:0] POL_SPARE = 2'd3;

   typedef struct packed {
      bit                       is_csr;
      csr_index_type            reg_sel;
      logic [CSR_DATA_WIDTH-1:0] reg_value;
      cmd_kind_type             op;
      logic [TAG_WIDTH-1:0]     tag;
      logic [BURST_WIDTH-1:0]   burst;
      logic [PRIO_WIDTH-1:0]    prio;
      int                       repeats;
      bit                       typed;
      rsp_type                  want;
   } directed_step_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic                       req_operation;
   logic [TAG_WIDTH-1:0]       req_job_tag;
   logic [BURST_WIDTH-1:0]     req_burst;
   logic [PRIO_WIDTH-1:0]      req_priority_req;
   logic                       rsp_valid;
   logic                       rsp_stopped;
   logic                       rsp_busy_res;
   logic [TAG_WIDTH-1:0]       rsp_running_tag;
   logic [TIME_WIDTH-1:0]      rsp_tick_time;
   logic                       rsp_finished;
   logic [TIME_WIDTH-1:0]      rsp_finish_time;
   logic [TIME_WIDTH-1:0]      rsp_turnaround;
   logic [TIME_WIDTH-1:0]      rsp_wait_time;
   logic                       rsp_arrival_lost;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   // Predicted dispatcher state, as it stands after reset.
   entry_type               ready_jobs [QUEUE_DEPTH];
   int                      queued      = 0;
   bit                      job_active  = 1'b0;
   logic [TAG_WIDTH-1:0]    job_tag_now = '0;
   logic [BURST_WIDTH-1:0]  job_left    = '0;
   logic [TIME_WIDTH-1:0]   job_arrival = '0;
   logic [TIME_WIDTH-1:0]   job_started = '0;
   logic [TIME_WIDTH-1:0]   cur_time    = '0;
   bit                      drop_seen   = 1'b0;
   logic [POLICY_WIDTH-1:0] policy_cfg  = POL_FCFS;
   logic [TIME_WIDTH-1:0]   limit_cfg   = '1;

   rsp_type tick_results_due [$];
   int      mismatches = 0;

   nonpreemptive_cpu_dispatcher u_dut (.*);

   always #(PERIOD / 2) clock = ~clock;

   function automatic rsp_type tick_result(input logic stopped, input logic ran,
                                           input logic [TAG_WIDTH-1:0] tag,
                                           input logic [TIME_WIDTH-1:0] tick_at,
                                           input logic done,
                                           input logic [TIME_WIDTH-1:0] done_at,
                                           input logic [TIME_WIDTH-1:0] turn,
                                           input logic [TIME_WIDTH-1:0] waited,
                                           input logic lost);
      rsp_type r;
      r.stopped      = stopped;
      r.busy_res     = ran;
      r.running_tag  = tag;
      r.tick_time    = tick_at;
      r.finished     = done;
      r.finish_time  = done_at;
      r.turnaround   = turn;
      r.wait_time    = waited;
      r.arrival_lost = lost;
      return r;
   endfunction

   function automatic void model_arrive(input logic [TAG_WIDTH-1:0] tag,
                                        input logic [BURST_WIDTH-1:0] burst,
                                        input logic [PRIO_WIDTH-1:0] prio);
      if (queued < QUEUE_DEPTH) begin
         ready_jobs[queued].tag     = tag;
         ready_jobs[queued].burst   = burst;
         ready_jobs[queued].prio    = prio;
         ready_jobs[queued].arrival = cur_time;
         queued++;
      end else begin
         drop_seen = 1'b1;
      end
   endfunction

   function automatic rsp_type model_tick();
      rsp_type               r;
      int                    pick;
      logic [TIME_WIDTH-1:0] done_at;
      r = '0;
      r.tick_time    = cur_time;
      r.arrival_lost = drop_seen;
      drop_seen      = 1'b0;
      if (cur_time >= limit_cfg) begin
         r.stopped = 1'b1;
         return r;
      end
      if (!job_active && queued != 0) begin
         // Strict comparisons keep the earlier-queued job on a tie.
         pick = 0;
         for (int i = 1; i < queued; i++) begin
            if (policy_cfg == POL_SJF) begin
               if (ready_jobs[i].burst < ready_jobs[pick].burst) pick = i;
            end else if (policy_cfg != POL_FCFS) begin
               if (ready_jobs[i].prio < ready_jobs[pick].prio) pick = i;
            end
         end
         job_tag_now = ready_jobs[pick].tag;
         job_left    = ready_jobs[pick].burst;
         job_arrival = ready_jobs[pick].arrival;
         job_started = cur_time;
         job_active  = 1'b1;
         for (int i = pick; i < queued - 1; i++) ready_jobs[i] = ready_jobs[i + 1];
         queued--;
      end
      if (job_active) begin
         r.busy_res    = 1'b1;
         r.running_tag = job_tag_now;
         if (job_left <= 1) begin
            done_at       = cur_time + 1'b1;
            r.finished    = 1'b1;
            r.finish_time = done_at;
            r.turnaround  = done_at - job_arrival;
            r.wait_time   = job_started - job_arrival;
            job_active    = 1'b0;
            job_left      = '0;
         end else begin
            job_left--;
         end
      end
      cur_time++;
      return r;
   endfunction

   function automatic directed_step_type csr_step(input csr_index_type sel,
                                                  input logic [CSR_DATA_WIDTH-1:0] value);
      directed_step_type s;
      s = '0;
      s.is_csr    = 1'b1;
      s.reg_sel   = sel;
      s.reg_value = value;
      return s;
   endfunction

   function automatic directed_step_type job_step(input cmd_kind_type op,
                                                  input logic [TAG_WIDTH-1:0] tag,
                                                  input logic [BURST_WIDTH-1:0] burst,
                                                  input logic [PRIO_WIDTH-1:0] prio,
                                                  input int repeats);
      directed_step_type s;
      s = '0;
      s.op      = op;
      s.tag     = tag;
      s.burst   = burst;
      s.prio    = prio;
      s.repeats = repeats;
      return s;
   endfunction

   function automatic directed_step_type known_tick(input rsp_type want);
      directed_step_type s;
      s = job_step(CMD_TICK, '0, '0, '0, 1);
      s.typed = 1'b1;
      s.want  = want;
      return s;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch, %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
   endtask

   // Called at a falling edge; lowers start and returns at a later falling edge.
   task automatic hold_off(input int cycles, input bit until_drained);
      start <= 1'b0;
      @(negedge clock);
      while (until_drained && tick_results_due.size() != 0) @(negedge clock);
      repeat (cycles) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type sel, input logic [CSR_DATA_WIDTH-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (sel == CSR_POLICY) policy_cfg = value[POLICY_WIDTH-1:0];
      else limit_cfg = value;
      @(negedge clock);
   endtask

   // Drives one command and waits for its transfer; leaves start high.
   task automatic issue(input cmd_kind_type op, input logic [TAG_WIDTH-1:0] tag,
                        input logic [BURST_WIDTH-1:0] burst,
                        input logic [PRIO_WIDTH-1:0] prio, input bit typed,
                        input rsp_type want);
      rsp_type predicted;
      start            <= 1'b1;
      req_operation    <= op;
      req_job_tag      <= tag;
      req_burst        <= burst;
      req_priority_req <= prio;
      do @(posedge clock); while (busy);
      if (op == CMD_ARRIVE) begin
         model_arrive(tag, burst, prio);
      end else begin
         predicted = model_tick();
         tick_results_due.push_back(typed ? want : predicted);
      end
      @(negedge clock);
   endtask

   always @(posedge clock) begin : result_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid) begin
         got = tick_result(rsp_stopped, rsp_busy_res, rsp_running_tag, rsp_tick_time,
                           rsp_finished, rsp_finish_time, rsp_turnaround, rsp_wait_time,
                           rsp_arrival_lost);
         if (tick_results_due.size() == 0) begin
            report_mismatch("result with no tick outstanding");
         end else begin
            want = tick_results_due.pop_front();
            check_field("stopped", 32'(got.stopped), 32'(want.stopped));
            check_field("busy_res", 32'(got.busy_res), 32'(want.busy_res));
            check_field("running_tag", 32'(got.running_tag), 32'(want.running_tag));
            check_field("tick_time", 32'(got.tick_time), 32'(want.tick_time));
            check_field("finished", 32'(got.finished), 32'(want.finished));
            check_field("finish_time", 32'(got.finish_time), 32'(want.finish_time));
            check_field("turnaround", 32'(got.turnaround), 32'(want.turnaround));
            check_field("wait_time", 32'(got.wait_time), 32'(want.wait_time));
            check_field("arrival_lost", 32'(got.arrival_lost), 32'(want.arrival_lost));
         end
      end
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      directed_step_type       plan [$];
      logic [POLICY_WIDTH-1:0] pol;
      logic [TIME_WIDTH-1:0]   lim;
      int                      count;
      bit                      wide;
      int                      arrive_pct;
      int                      idle_pct;
      int                      done;
      logic [TAG_WIDTH-1:0]    tag;
      logic [BURST_WIDTH-1:0]  burst;
      logic [PRIO_WIDTH-1:0]   prio;

      reset            <= 1'b1;
      start            <= 1'b0;
      req_operation    <= CMD_ARRIVE;
      req_job_tag      <= '0;
      req_burst        <= '0;
      req_priority_req <= '0;
      csr_we           <= 1'b0;
      csr_index        <= CSR_POLICY;
      csr_wdata        <= '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // With a limit of one only the tick at time zero runs; the rest are stopped.
      plan.push_back(csr_step(CSR_TIME_LIMIT, 16'd1));
      plan.push_back(known_tick(tick_result(0, 0, 0, 0, 0, 0, 0, 0, 0)));
      plan.push_back(job_step(CMD_ARRIVE, 8'h00, 16'h0000, 8'h00, 1));
      plan.push_back(known_tick(tick_result(1, 0, 0, 1, 0, 0, 0, 0, 0)));
      plan.push_back(csr_step(CSR_TIME_LIMIT, 16'hFFFF));
      // A burst of zero still takes one tick.
      plan.push_back(known_tick(tick_result(0, 1, 8'h00, 1, 1, 2, 1, 0, 0)));
      // Shortest burst with a tie between the two one-unit jobs.
      plan.push_back(csr_step(CSR_POLICY, CSR_DATA_WIDTH'(POL_SJF)));
      plan.push_back(job_step(CMD_ARRIVE, 8'hA1, 16'd2, 8'd9, 1));
      plan.push_back(job_step(CMD_ARRIVE, 8'h5E, 16'd1, 8'd200, 1));
      plan.push_back(job_step(CMD_ARRIVE, 8'h3C, 16'd1, 8'd4, 1));
      plan.push_back(job_step(CMD_TICK, 8'h00, 16'd0, 8'd0, 1));
      plan.push_back(csr_step(CSR_POLICY, CSR_DATA_WIDTH'(POL_PRIO)));
      plan.push_back(job_step(CMD_TICK, 8'hFF, 16'hFFFF, 8'hFF, 1));
      // The spare policy code, a priority tie, then a full queue and a dropped arrival.
      plan.push_back(csr_step(CSR_POLICY, CSR_DATA_WIDTH'(POL_SPARE)));
      plan.push_back(job_step(CMD_ARRIVE, 8'h44, 16'd0, 8'd9, 1));
      plan.push_back(job_step(CMD_ARRIVE, 8'hF0, 16'd1, 8'd1, 14));
      plan.push_back(job_step(CMD_ARRIVE, 8'hFF, 16'hFFFF, 8'hFF, 1));
      plan.push_back(job_step(CMD_TICK, 8'h00, 16'd0, 8'd0, 1));
      plan.push_back(csr_step(CSR_POLICY, CSR_DATA_WIDTH'(POL_FCFS)));
      plan.push_back(job_step(CMD_TICK, 8'h00, 16'd0, 8'd0, 1));

      foreach (plan[s]) begin
         if (plan[s].is_csr) begin
            hold_off(SETTLE_CYCLES, 1'b1);
            write_csr(plan[s].reg_sel, plan[s].reg_value);
         end else begin
            repeat (plan[s].repeats)
               issue(plan[s].op, plan[s].tag, plan[s].burst, plan[s].prio, plan[s].typed,
                     plan[s].want);
         end
      end

      done       = 0;
      arrive_pct = 25;
      for (int p = 0; p < NUM_PHASES; p++) begin
         wide  = 1'b0;
         count = 300;
         lim   = 16'hFFFF;
         case (p)
            0: pol = POL_FCFS;
            1: pol = POL_SJF;
            2: pol = POL_PRIO;
            3: begin
               pol   = POL_SPARE;
               count = 250;
            end
            4: begin
               // The limit falls part way through, so the later ticks are stopped.
               pol   = POL_SJF;
               lim   = cur_time + 16'd40;
               count = 200;
            end
            default: begin
               // Everything stops here, so bursts of any size can be queued safely.
               pol   = POL_FCFS;
               lim   = 16'd1;
               count = 200;
               wide  = 1'b1;
            end
         endcase
         hold_off(SETTLE_CYCLES, 1'b1);
         write_csr(CSR_POLICY, CSR_DATA_WIDTH'(pol));
         write_csr(CSR_TIME_LIMIT, lim);

         for (int n = 0; n < count; n++) begin
            // Stretches of heavy arrival fill the queue; light ones let it drain.
            if (n % 40 == 0) arrive_pct = $urandom_range(0, 1) ? 25 : 75;
            idle_pct = (done < RANDOM_ITEMS / 3) ? 11 :
                       (done < 2 * RANDOM_ITEMS / 3) ? 58 : 0;
            tag = TAG_WIDTH'($urandom_range(0, 255));
            if (wide) burst = BURST_WIDTH'($urandom_range(0, 65535));
            else if ($urandom_range(0, 15) == 0) burst = BURST_WIDTH'($urandom_range(5, 30));
            else burst = BURST_WIDTH'($urandom_range(0, 4));
            prio = PRIO_WIDTH'($urandom_range(0, 1) ? $urandom_range(0, 3) :
                                                      $urandom_range(0, 255));
            issue(($urandom_range(0, 99) < arrive_pct) ? CMD_ARRIVE : CMD_TICK,
                  tag, burst, prio, 1'b0, '0);
            done++;
            if ($urandom_range(0, 99) == 0) hold_off(0, 1'b1);
            else if ($urandom_range(0, 99) < idle_pct) hold_off(0, 1'b0);
         end
      end

      hold_off(SETTLE_CYCLES, 1'b1);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/npcd_pkg.sv
rtl/npcd_ram.sv
rtl/npcd_front.sv
rtl/npcd_back.sv
rtl/nonpreemptive_cpu_dispatcher.sv
dv/testbench.sv
